@@ rtl/idia_pkg.sv @@
// Shared types and codes for the indexed insert/delete array unit.
package idia_pkg;

  // Field widths of the transfers
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_POS  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } idia_in_t;

  // Result payload
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
  } idia_out_t;

endpackage

@@ rtl/indexed_insert_delete_array_unit.sv @@
// Top level of the indexed insert/delete array unit: sequencer, entry memory, result register.
//
//  channel  ports                         transfer when
//  request  start, busy, in_item          start high and busy low at a rising edge
//  result   out_strobe, out_item          out_strobe high for one cycle
//
// After an accepted request busy stays high until the result goes out: a rejected request,
// an unused code or a delete of the last entry goes straight to S_RESP; a read waits in
// S_RD_WAIT; an append writes in S_INS_PUT; an insert that shifts walks S_INS_MV, then
// S_INS_PUT; a delete that shifts walks S_DEL_MV. The shift moves one entry per cycle
// through the single memory port pair. out_strobe rises at the edge where busy falls.
// Reset (rst_n low, synchronous) empties the array; entries are not cleared.
// The receiver cannot stall; the result is shown for exactly one cycle.
module indexed_insert_delete_array_unit import idia_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  idia_in_t  in_item,
  output logic      out_strobe,
  output idia_out_t out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                      done;
  idia_out_t                 res;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic signed [VALUE_W-1:0] mem_wdata, mem_rdata;
  logic                      out_strobe_r;
  idia_out_t                 out_item_r;

  idia_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_item),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  idia_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Strobe the result transfer for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= done;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (done) begin
      out_item_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ rtl/idia_mem.sv @@
// Entry storage: one write port and one registered read port.
module idia_mem import idia_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/idia_ctrl.sv @@
// Sequencer: checks a request, walks the entry shift one entry per cycle, keeps the count.
module idia_ctrl import idia_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  idia_in_t                  req,
  output logic                      busy,
  output logic                      done,
  output idia_out_t                 res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic signed [VALUE_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic signed [VALUE_W-1:0] mem_rdata
);

  localparam int EW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_MV  = 6'b000010,
    S_INS_PUT = 6'b000100,
    S_DEL_MV  = 6'b001000,
    S_RD_WAIT = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [STAT_W-1:0]         status_r, status_nxt;
  logic signed [VALUE_W-1:0] rdval_r, rdval_nxt;
  logic [EW-1:0]             pos_e, cnt_e;

  // Compare position and count at a common width
  assign pos_e = EW'(req.position);
  assign cnt_e = EW'(count_r);

  // Next-state and memory command
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    rdval_nxt  = rdval_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    done       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt    = AW'(req.position);
          val_nxt    = req.value;
          status_nxt = STAT_OK;
          rdval_nxt  = '0;
          state_nxt  = S_RESP;
          unique case (req.func)
            FUNC_INSERT: begin
              priority if (count_r == CW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
              end else if (pos_e > cnt_e) begin
                status_nxt = STAT_POS;
              end else if (pos_e == cnt_e) begin
                state_nxt = S_INS_PUT;
              end else begin
                // Fetch the last entry; it moves up first
                mem_re    = 1'b1;
                mem_raddr = AW'(count_r - CW'(1));
                idx_nxt   = AW'(count_r);
                state_nxt = S_INS_MV;
              end
            end
            FUNC_DELETE: begin
              priority if (pos_e >= cnt_e) begin
                status_nxt = STAT_POS;
              end else if (pos_e == cnt_e - EW'(1)) begin
                count_nxt = count_r - CW'(1);
              end else begin
                // Fetch the entry above the hole
                mem_re    = 1'b1;
                mem_raddr = AW'(req.position) + AW'(1);
                idx_nxt   = AW'(req.position);
                state_nxt = S_DEL_MV;
              end
            end
            FUNC_READ: begin
              if (pos_e >= cnt_e) begin
                status_nxt = STAT_POS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(req.position);
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_INS_MV: begin
        // Move one entry up, fetch the next one below
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (idx_r - AW'(1) == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(2);
          idx_nxt   = idx_r - AW'(1);
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_DEL_MV: begin
        // Move one entry down, fetch the next one above
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (CW'(idx_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(2);
          idx_nxt   = idx_r + AW'(1);
        end
      end
      S_RD_WAIT: begin
        rdval_nxt = mem_rdata;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    rdval_r  <= rdval_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign res.status     = status_r;
  assign res.read_value = rdval_r;
  assign res.count      = COUNT_W'(count_r);

endmodule

@@ tb/sv/idia_array_checker.sv @@
// Predictor and scoreboard for the indexed insert/delete array unit.
module idia_array_checker import idia_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  idia_in_t  in_item,
  input  logic      out_strobe,
  input  idia_out_t out_item,
  output int        fail_count,
  output int        pending_results
);

  // Shadow copy of the array contents and fill level
  logic signed [VALUE_W-1:0] entries [CAPACITY];
  int                        entry_count;
  idia_out_t                 expected_q [$];
  int                        mismatches;

  // Apply one operation to the shadow array and return the result it must give
  function automatic idia_out_t apply_array_op(input idia_in_t op);
    idia_out_t res;
    res.status     = STAT_OK;
    res.read_value = '0;
    case (op.func)
      FUNC_INSERT: begin
        // a full array refuses before the position is looked at
        if (entry_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else if (op.position > entry_count) begin
          res.status = STAT_POS;
        end else begin
          for (int i = entry_count; i > op.position; i--) entries[i] = entries[i - 1];
          entries[op.position] = op.value;
          entry_count++;
        end
      end
      FUNC_DELETE: begin
        if (op.position >= entry_count) begin
          res.status = STAT_POS;
        end else begin
          for (int i = op.position; i + 1 < entry_count; i++) entries[i] = entries[i + 1];
          entry_count--;
        end
      end
      FUNC_READ: begin
        if (op.position >= entry_count) res.status = STAT_POS;
        else res.read_value = entries[op.position];
      end
      // unused code: leave everything as it is
      default: ;
    endcase
    res.count = COUNT_W'(entry_count);
    return res;
  endfunction

  // Compare one result transfer against the oldest expectation
  task automatic check_result(input idia_out_t got);
    idia_out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d read_value %0d count %0d",
             got.status, got.read_value, got.count);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
    end
  endtask

  // Watch both channels; check results before queuing the new transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      entry_count = 0;
      expected_q.delete();
    end else begin
      if (out_strobe !== 1'b0) check_result(out_item);
      if (start && !busy) expected_q.push_back(apply_array_op(in_item));
    end
    pending_results <= expected_q.size();
    fail_count      <= mismatches;
  end

endmodule

@@ tb/sv/indexed_insert_delete_array_unit_tb.sv @@
// Stimulus, clock, reset and verdict for the indexed insert/delete array unit.
module indexed_insert_delete_array_unit_tb;
  import idia_pkg::*;

  localparam int ARRAY_DEPTH  = 64;
  localparam int RANDOM_OPS   = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int QUIET_FIRST  = 800;
  localparam int QUIET_LAST   = 1100;

  localparam logic [FUNC_W-1:0]         FUNC_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;

  // Growth modes of a random burst
  localparam int MODE_GROW    = 0;
  localparam int MODE_SHRINK  = 1;
  localparam int MODE_BALANCE = 2;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      out_strobe;
  idia_in_t  in_item;
  idia_out_t out_item;

  int fail_count;
  int pending_results;
  int cycle_count;
  int fill_est;   // expected fill level, used only to steer positions
  bit gaps_on;

  indexed_insert_delete_array_unit #(.CAPACITY(ARRAY_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  idia_array_checker #(.CAPACITY(ARRAY_DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[indexed_insert_delete_array_unit] ERROR");
      $finish;
    end
  end

  // Issue one operation and hold it until the block takes the transfer
  task automatic send_op(input logic [FUNC_W-1:0] func, input int pos,
                         input logic signed [VALUE_W-1:0] val);
    idia_in_t op;
    op.func     = func;
    op.position = POS_W'(pos);
    op.value    = val;
    // idle the request line at random
    while (gaps_on && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    // follow the fill level so later positions stay mostly in range
    case (func)
      FUNC_INSERT: if (fill_est < ARRAY_DEPTH && pos <= fill_est) fill_est++;
      FUNC_DELETE: if (pos < fill_est) fill_est--;
      default: ;
    endcase
  endtask

  // Pick a position at the ends or anywhere up to the given bound
  function automatic int pick_position(input int upper);
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 0;
    if (pick == 1) return upper;
    return $urandom_range(0, upper);
  endfunction

  // Build and send one random operation, mostly well formed
  task automatic send_random_op(input int mode);
    int                        roll;
    int                        op_roll;
    int                        pos;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] val;
    roll    = $urandom_range(0, 99);
    op_roll = $urandom_range(0, 99);
    val     = $urandom;
    if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
    if (roll < 8) begin
      // noise: any code, any position the field can carry
      func = FUNC_W'($urandom_range(0, 3));
      pos  = $urandom_range(0, 127);
    end else begin
      case (mode)
        MODE_GROW:   func = op_roll < 75 ? FUNC_INSERT : (op_roll < 85 ? FUNC_DELETE : FUNC_READ);
        MODE_SHRINK: func = op_roll < 70 ? FUNC_DELETE : (op_roll < 80 ? FUNC_INSERT : FUNC_READ);
        default:     func = op_roll < 45 ? FUNC_INSERT : (op_roll < 80 ? FUNC_DELETE : FUNC_READ);
      endcase
      if (func == FUNC_INSERT) pos = pick_position(fill_est);
      else if (fill_est == 0) pos = $urandom_range(0, 1);
      else pos = pick_position(fill_est - 1);
    end
    send_op(func, pos, val);
  endtask

  initial begin
    int done;
    int burst_len;
    int mode;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    gaps_on  = 1'b1;
    fill_est = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty array, extremes, shifts, bad positions, unused code
    send_op(FUNC_READ,   0,   '0);
    send_op(FUNC_DELETE, 0,   '0);
    send_op(FUNC_INSERT, 1,   32'sd5);
    send_op(FUNC_INSERT, 0,   VALUE_MAX);
    send_op(FUNC_INSERT, 1,   VALUE_MIN);
    send_op(FUNC_INSERT, 0,   -32'sd1);
    send_op(FUNC_INSERT, 1,   '0);
    for (int i = 0; i <= 4; i++) send_op(FUNC_READ, i, VALUE_MAX);
    send_op(FUNC_READ,   127, '0);
    send_op(FUNC_UNUSED, 0,   32'sh5555_5555);
    send_op(FUNC_INSERT, 127, VALUE_MIN);
    send_op(FUNC_DELETE, 127, '0);
    send_op(FUNC_DELETE, 1,   '0);
    send_op(FUNC_DELETE, 2,   '0);
    send_op(FUNC_READ,   0,   '0);
    send_op(FUNC_READ,   1,   '0);
    send_op(FUNC_INSERT, 6,   32'shAAAA_AAAA);
    send_op(FUNC_DELETE, 0,   '0);
    send_op(FUNC_DELETE, 0,   '0);
    send_op(FUNC_READ,   0,   '0);

    // Random bursts that fill, drain or churn the array
    done = 0;
    while (done < RANDOM_OPS) begin
      mode      = $urandom_range(MODE_GROW, MODE_BALANCE);
      burst_len = $urandom_range(20, 150);
      for (int k = 0; k < burst_len && done < RANDOM_OPS; k++) begin
        gaps_on = !(done >= QUIET_FIRST && done < QUIET_LAST);
        send_random_op(mode);
        done++;
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then give the block time to misbehave
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[indexed_insert_delete_array_unit] OK");
    end else begin
      $display("[indexed_insert_delete_array_unit] ERROR");
    end
    $finish;
  end

endmodule
